// File: rtl/tss_pkg.sv
package tss_pkg;

   // Largest node number; a tree holds the root plus up to this many nodes.
   localparam int MAX_NODES = 8;

   // Fixed field widths of the item and result channels.
   localparam int VALUE_W  = 16;
   localparam int PARENT_W = 4;
   localparam int SUM_W    = 20;
   localparam int ID_W     = 4;

   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [PARENT_W-1:0] parent_type;
   typedef logic [SUM_W-1:0]    sum_type;
   typedef logic [ID_W-1:0]     id_type;

endpackage

// File: rtl/tree_subtree_sum.sv
// Subtree sums of a rooted tree loaded as a parent array. Send the root's value first, then
// one item per node 1..n with its 1-based parent (0 means the root), and mark the final node
// with req_last_node. Items are taken one per cycle while busy is low. After the final item
// busy rises while the block orders the nodes breadth first, folds each node's sum into its
// parent, and then presents one result per node 0..n on consecutive cycles, each for exactly
// one cycle with rsp_valid high; the receiver cannot stall and must take every result as it
// appears. A parent array that is not a tree, or a run of more than MAX_NODES+1 items, gives
// tree_error on every result with a zero sum. For n nodes, the breadth-first ordering makes
// at most n passes over the parent memory; each pass picks the node whose children it
// collects, reads every parent entry and drains the last compare, and a final fetch sees
// every node placed. The fold steps through S_RED1 to S_RED4 for each node, since the sum
// memory has a single read port; the results then stream out one per cycle. The slowest
// tree is a single chain, and busy drops in the cycle that shows the final result.
module tree_subtree_sum (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  tss_pkg::value_type       req_node_value,
   input  tss_pkg::parent_type      req_parent_index,
   input  logic                     req_last_node,
   output logic                     rsp_valid,
   output tss_pkg::sum_type         rsp_subtree_sum,
   output tss_pkg::id_type          rsp_node_id,
   output logic                     rsp_tree_error,
   output logic                     rsp_last_result
);

   localparam int MAX_NODES = tss_pkg::MAX_NODES;

   // Node ids run 0..MAX_NODES; the parent and order memories hold nodes 1..MAX_NODES.
   localparam int IW   = $clog2(MAX_NODES + 1);
   localparam int PAW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNTW = $clog2(MAX_NODES + 2);
   localparam int CW   = (IW > tss_pkg::PARENT_W) ? IW : tss_pkg::PARENT_W;

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_FETCH = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_DRAIN = 4'd3;
   localparam logic [3:0] S_RED1  = 4'd4;
   localparam logic [3:0] S_RED2  = 4'd5;
   localparam logic [3:0] S_RED3  = 4'd6;
   localparam logic [3:0] S_RED4  = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;

   // Control registers.
   logic [3:0]      state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            ovf_ff, ovf_in;
   logic [IW-1:0]   n_ff, n_in;
   logic            err_ff, err_in;
   logic            root_pass_ff, root_pass_in;
   logic [IW-1:0]   size_ff, size_in;
   logic [IW-1:0]   cur_ff, cur_in;
   logic [IW-1:0]   scan_ff, scan_in;
   logic            cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0]   cmp_node_ff, cmp_node_in;
   logic [IW-1:0]   k_ff, k_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   tss_pkg::sum_type node_sum_ff, node_sum_in;
   tss_pkg::id_type  rsp_node_ff, rsp_node_in;
   logic             rsp_last_ff, rsp_last_in;

   // Memories and their ports.
   tss_pkg::sum_type    sum_mem [MAX_NODES+1];
   tss_pkg::sum_type    sum_rd_ff;
   logic                sum_we, sum_re;
   logic [IW-1:0]       sum_waddr, sum_raddr;
   tss_pkg::sum_type    sum_wdata;

   tss_pkg::parent_type parent_mem [MAX_NODES];
   tss_pkg::parent_type par_rd_ff;
   logic                par_we, par_re;
   logic [PAW-1:0]      par_waddr, par_raddr;

   logic [IW-1:0]       order_mem [MAX_NODES];
   logic [IW-1:0]       order_rd_ff;
   logic                order_we, order_re;
   logic [PAW-1:0]      order_waddr, order_raddr;

   // Helpers.
   logic            accept;
   logic            stored;
   logic [CNTW-1:0] cnt_m1;
   logic [IW-1:0]   n_m1, k_m1, node_m1;
   logic [CW-1:0]   par_wide, tgt_wide, k_wide;
   logic            hit;

   assign accept   = start && (state_ff == S_LOAD);
   assign stored   = (cnt_ff <= CNTW'(MAX_NODES));
   assign cnt_m1   = cnt_ff - CNTW'(1);
   assign n_m1     = n_ff - IW'(1);
   assign k_m1     = k_ff - IW'(1);
   assign node_m1  = order_rd_ff - IW'(1);
   assign par_wide = CW'(par_rd_ff);
   assign tgt_wide = root_pass_ff ? '0 : CW'(order_rd_ff);
   assign k_wide   = CW'(k_ff);
   // A parent out of range never matches a node id, so that node stays unreached.
   assign hit      = cmp_valid_ff && (par_wide == tgt_wide) && (size_ff < n_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      err_in       = err_ff;
      root_pass_in = root_pass_ff;
      size_in      = size_ff;
      cur_in       = cur_ff;
      scan_in      = scan_ff;
      cmp_valid_in = 1'b0;
      cmp_node_in  = cmp_node_ff;
      k_in         = k_ff;
      node_sum_in  = node_sum_ff;
      rsp_valid_in = 1'b0;
      rsp_node_in  = rsp_node_ff;
      rsp_last_in  = rsp_last_ff;

      sum_we      = 1'b0;
      sum_waddr   = cnt_ff[IW-1:0];
      sum_wdata   = tss_pkg::SUM_W'(req_node_value);
      sum_re      = 1'b0;
      sum_raddr   = k_ff;
      par_we      = 1'b0;
      par_waddr   = cnt_m1[PAW-1:0];
      par_re      = 1'b0;
      par_raddr   = scan_ff[PAW-1:0];
      order_we    = 1'b0;
      order_waddr = size_ff[PAW-1:0];
      order_re    = 1'b0;
      order_raddr = cur_ff[PAW-1:0];

      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (stored) begin
                  sum_we = 1'b1;
                  par_we = (cnt_ff != '0);
                  cnt_in = cnt_ff + CNTW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_node) begin
                  n_in         = stored ? cnt_ff[IW-1:0] : IW'(MAX_NODES);
                  err_in       = ovf_ff || !stored;
                  cnt_in       = '0;
                  ovf_in       = 1'b0;
                  root_pass_in = 1'b1;
                  size_in      = '0;
                  cur_in       = '0;
                  k_in         = '0;
                  state_in     = (ovf_ff || !stored) ? S_EMIT : S_FETCH;
               end
            end
         end
         S_FETCH: begin
            // Start of one breadth-first pass: pick up the node whose children we collect.
            scan_in = '0;
            if (size_ff == n_ff) begin
               k_in     = n_ff;
               state_in = (n_ff == '0) ? S_EMIT : S_RED1;
            end else if (!root_pass_ff && (cur_ff >= size_ff)) begin
               err_in   = 1'b1;
               k_in     = '0;
               state_in = S_EMIT;
            end else begin
               order_re = !root_pass_ff;
               state_in = S_SCAN;
            end
         end
         S_SCAN, S_DRAIN: begin
            if (hit) begin
               order_we = 1'b1;
               size_in  = size_ff + IW'(1);
            end
            if (state_ff == S_SCAN) begin
               par_re       = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_node_in  = scan_ff + IW'(1);
               scan_in      = scan_ff + IW'(1);
               if (scan_ff == n_m1) begin
                  state_in = S_DRAIN;
               end
            end else begin
               if (root_pass_ff) begin
                  root_pass_in = 1'b0;
               end else begin
                  cur_in = cur_ff + IW'(1);
               end
               state_in = S_FETCH;
            end
         end
         S_RED1: begin
            order_re    = 1'b1;
            order_raddr = k_m1[PAW-1:0];
            state_in    = S_RED2;
         end
         S_RED2: begin
            par_re    = 1'b1;
            par_raddr = node_m1[PAW-1:0];
            sum_re    = 1'b1;
            sum_raddr = order_rd_ff;
            state_in  = S_RED3;
         end
         S_RED3: begin
            node_sum_in = sum_rd_ff;
            sum_re      = 1'b1;
            sum_raddr   = par_wide[IW-1:0];
            state_in    = S_RED4;
         end
         S_RED4: begin
            // The write lands before the next step reads the sum memory, so no bypass is needed.
            sum_we    = 1'b1;
            sum_waddr = par_wide[IW-1:0];
            sum_wdata = sum_rd_ff + node_sum_ff;
            k_in      = k_m1;
            state_in  = (k_ff == IW'(1)) ? S_EMIT : S_RED1;
         end
         S_EMIT: begin
            sum_re       = 1'b1;
            sum_raddr    = k_ff;
            rsp_valid_in = 1'b1;
            rsp_node_in  = k_wide[tss_pkg::ID_W-1:0];
            rsp_last_in  = (k_ff == n_ff);
            k_in         = k_ff + IW'(1);
            if (k_ff == n_ff) begin
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         n_ff         <= '0;
         err_ff       <= 1'b0;
         root_pass_ff <= 1'b0;
         size_ff      <= '0;
         cur_ff       <= '0;
         scan_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         cmp_node_ff  <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         n_ff         <= n_in;
         err_ff       <= err_in;
         root_pass_ff <= root_pass_in;
         size_ff      <= size_in;
         cur_ff       <= cur_in;
         scan_ff      <= scan_in;
         cmp_valid_ff <= cmp_valid_in;
         cmp_node_ff  <= cmp_node_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_sum_ff <= node_sum_in;
      rsp_node_ff <= rsp_node_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      if (sum_re) begin
         sum_rd_ff <= sum_mem[sum_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         parent_mem[par_waddr] <= req_parent_index;
      end
      if (par_re) begin
         par_rd_ff <= parent_mem[par_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (order_we) begin
         order_mem[order_waddr] <= cmp_node_ff;
      end
      if (order_re) begin
         order_rd_ff <= order_mem[order_raddr];
      end
   end

   assign busy            = (state_ff != S_LOAD);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_subtree_sum = err_ff ? '0 : sum_rd_ff;
   assign rsp_node_id     = rsp_node_ff;
   assign rsp_tree_error  = err_ff;
   assign rsp_last_result = rsp_last_ff;

   // The level order never grows past the node count.
   a_order_bound: assert property (@(posedge clock) disable iff (reset)
      order_we |-> (size_ff < n_ff))
      else $error("level order written beyond node count");

   // The fold runs only on a tree that passed the ordering.
   a_fold_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RED1 || state_ff == S_RED4) |-> !err_ff)
      else $error("fold entered with error set");

   // Results within a run carry consecutive node ids.
   a_ids_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |=>
         (rsp_valid_ff && (rsp_node_ff == $past(rsp_node_ff) + tss_pkg::ID_W'(1))))
      else $error("result node ids not consecutive");

   // The final result of a run is followed by a gap.
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |=> !rsp_valid_ff)
      else $error("result after final result");

endmodule

// File: bench/tree_subtree_sum_test.sv
`timescale 1ns / 1ps

module tree_subtree_sum_test;

   localparam int MAX_NODES   = tss_pkg::MAX_NODES;
   localparam int ITEM_TARGET = 370;
   // The sender idles often in the first part of the run, heavily in the second part, and
   // not at all in the last part. These are item counts that mark the part boundaries.
   localparam int HEAVY_IDLE_FROM = 150;
   localparam int NO_IDLE_FROM    = 260;
   // The slowest tree inside the block is a full tree of nine nodes in a single chain, and
   // this drain covers it with room to spare.
   localparam int DRAIN_CYCLES = 200;
   // The limit sits well above the slowest correct run, even with the heaviest idling.
   localparam int CYCLE_LIMIT  = 400000;

   // How a directed row is checked. Most rows go through the predictor; a few rows have
   // results that are obvious from the stimulus, and those are typed in directly.
   typedef enum bit [1:0] {
      CHECK_PREDICTED,
      CHECK_SINGLE_ROOT,
      CHECK_ALL_ERROR
   } check_kind_type;

   typedef struct packed {
      tss_pkg::value_type  value;
      tss_pkg::parent_type parent;
      logic                last;
      check_kind_type      kind;
      tss_pkg::sum_type    exp_sum;
      tss_pkg::id_type     exp_count;
   } stim_row_type;

   typedef struct packed {
      tss_pkg::sum_type sum;
      tss_pkg::id_type  node;
      logic             error;
      logic             last;
   } subtree_result_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   tss_pkg::value_type  req_node_value;
   tss_pkg::parent_type req_parent_index;
   logic                req_last_node;
   logic                rsp_valid;
   tss_pkg::sum_type    rsp_subtree_sum;
   tss_pkg::id_type     rsp_node_id;
   logic                rsp_tree_error;
   logic                rsp_last_result;

   // Check mode that travels with the item on the request ports, so that the checker sees
   // it at the same edge that accepts the item.
   check_kind_type   row_kind;
   tss_pkg::sum_type row_sum;
   tss_pkg::id_type  row_count;

   // Private copy of the block's tree state, kept by the predictor.
   tss_pkg::sum_type    node_sum   [MAX_NODES+1];
   tss_pkg::parent_type parent_of  [MAX_NODES];
   tss_pkg::id_type     bfs_order  [MAX_NODES];
   int                  nodes_loaded;
   bit                  overflowed;

   subtree_result_type expected_sums[$];
   subtree_result_type fresh_sums[$];

   int mismatch_count;
   int items_sent;
   int cycle_count;

   // The directed part. It starts right after reset with a lone root, then a full tree whose
   // root sum reaches the widest value, then each way a tree can be broken, and finally a run
   // with one item too many.
   stim_row_type directed_rows[$] = '{
      // A lone root after reset; its parent field carries the top value and must be ignored.
      '{16'd0,     4'd8, 1'b1, CHECK_SINGLE_ROOT, 20'd0, 4'd1},
      // Nine nodes at full value: seven leaves hang from node 8, which hangs from the root.
      '{16'hFFFF,  4'd0, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'hFFFF,  4'd8, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'hFFFF,  4'd8, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'hFFFF,  4'd8, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'hFFFF,  4'd8, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'hFFFF,  4'd8, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'hFFFF,  4'd8, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'hFFFF,  4'd8, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'hFFFF,  4'd0, 1'b1, CHECK_PREDICTED,   20'd0, 4'd0},
      // A parent that names a node beyond the end of the tree.
      '{16'd1234,  4'd0, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'd0,     4'd2, 1'b1, CHECK_ALL_ERROR,   20'd0, 4'd2},
      // A node that is its own parent.
      '{16'd7,     4'd0, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'd9,     4'd1, 1'b1, CHECK_ALL_ERROR,   20'd0, 4'd2},
      // Two nodes that point at each other and never reach the root.
      '{16'd100,   4'd0, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'd200,   4'd2, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'd300,   4'd1, 1'b1, CHECK_ALL_ERROR,   20'd0, 4'd3},
      // Ten items: the tenth is dropped and the whole run reports an error on nine results.
      '{16'h5555,  4'd0, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'hAAAA,  4'd0, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'h5555,  4'd1, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'hAAAA,  4'd2, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'h5555,  4'd3, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'hAAAA,  4'd4, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'h5555,  4'd5, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'hAAAA,  4'd6, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'h5555,  4'd7, 1'b0, CHECK_PREDICTED,   20'd0, 4'd0},
      '{16'hAAAA,  4'd8, 1'b1, CHECK_ALL_ERROR,   20'd0, 4'd9}
   };

   tree_subtree_sum dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_node_value  (req_node_value),
      .req_parent_index(req_parent_index),
      .req_last_node   (req_last_node),
      .rsp_valid       (rsp_valid),
      .rsp_subtree_sum (rsp_subtree_sum),
      .rsp_node_id     (rsp_node_id),
      .rsp_tree_error  (rsp_tree_error),
      .rsp_last_result (rsp_last_result)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Breadth-first order of nodes 1..n, found the way the block finds it: all children of
   // the root first, then the children of each ordered node in turn. Returns 1 only when
   // every node was reached, which is exactly the case of a valid tree.
   function automatic bit order_breadth_first(int n);
      int filled;
      int cur;
      filled = 0;
      cur = 0;
      for (int i = 0; i < n; i++)
         if (parent_of[i] == '0 && filled < n) begin
            bfs_order[filled] = tss_pkg::id_type'(i + 1);
            filled++;
         end
      while (filled < n && cur < filled) begin
         for (int i = 0; i < n; i++)
            if (parent_of[i] == bfs_order[cur] && filled < n) begin
               bfs_order[filled] = tss_pkg::id_type'(i + 1);
               filled++;
            end
         cur++;
      end
      return filled == n;
   endfunction

   // Takes one accepted item into the predicted tree state. On the final node of a tree it
   // fills fresh_sums with one result per node and starts a new tree.
   function automatic void predict_tree_item(tss_pkg::value_type value,
                                             tss_pkg::parent_type parent, logic last);
      int n;
      int k;
      int node;
      bit broken;
      subtree_result_type res;
      fresh_sums.delete();
      if (nodes_loaded <= MAX_NODES) begin
         node_sum[nodes_loaded] = tss_pkg::sum_type'(value);
         if (nodes_loaded > 0)
            parent_of[nodes_loaded-1] = parent;
         nodes_loaded++;
      end else begin
         overflowed = 1'b1;
      end
      if (!last)
         return;
      n = nodes_loaded - 1;
      broken = overflowed || !order_breadth_first(n);
      // Deepest nodes first, so each node's sum is complete before it goes to its parent.
      if (!broken)
         for (k = n; k > 0; k--) begin
            node = bfs_order[k-1];
            node_sum[parent_of[node-1]] = node_sum[parent_of[node-1]] + node_sum[node];
         end
      for (k = 0; k <= n; k++) begin
         res = '{broken ? tss_pkg::sum_type'(0) : node_sum[k], tss_pkg::id_type'(k), broken,
                 k == n};
         fresh_sums.insert(fresh_sums.size(), res);
      end
      nodes_loaded = 0;
      overflowed = 1'b0;
   endfunction

   function automatic void clear_tree_state();
      foreach (node_sum[i])
         node_sum[i] = '0;
      foreach (parent_of[i])
         parent_of[i] = '0;
      foreach (bfs_order[i])
         bfs_order[i] = '0;
      nodes_loaded = 0;
      overflowed = 1'b0;
   endfunction

   // Checker. Everything is sampled at the rising edge, before the nonblocking updates of
   // that edge land, so the values seen are those of the cycle that the edge ends. A result
   // in that cycle can never belong to an item accepted at the same edge, so the result is
   // checked first and the item's expectations are queued after it.
   always @(posedge clock) begin
      subtree_result_type want;
      subtree_result_type res;
      if (reset) begin
         clear_tree_state();
         expected_sums.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_sums.size() == 0) begin
               report_mismatch($sformatf("result for node %0d with nothing expected",
                                         rsp_node_id));
            end else begin
               want = expected_sums.pop_front();
               if (rsp_subtree_sum !== want.sum)
                  report_mismatch($sformatf("node %0d sum %0d, expected %0d", want.node,
                                            rsp_subtree_sum, want.sum));
               if (rsp_node_id !== want.node)
                  report_mismatch($sformatf("node id %0d, expected %0d", rsp_node_id,
                                            want.node));
               if (rsp_tree_error !== want.error)
                  report_mismatch($sformatf("node %0d error flag %b, expected %b", want.node,
                                            rsp_tree_error, want.error));
               if (rsp_last_result !== want.last)
                  report_mismatch($sformatf("node %0d last flag %b, expected %b", want.node,
                                            rsp_last_result, want.last));
            end
         end
         if (start && !busy) begin
            // The predictor always runs so that its tree state follows the block. For rows
            // whose answer is typed in, that typed answer is what gets checked.
            predict_tree_item(req_node_value, req_parent_index, req_last_node);
            case (row_kind)
               CHECK_SINGLE_ROOT: begin
                  res = '{row_sum, tss_pkg::id_type'(0), 1'b0, 1'b1};
                  expected_sums.insert(expected_sums.size(), res);
               end
               CHECK_ALL_ERROR: begin
                  for (int k = 0; k < row_count; k++) begin
                     res = '{tss_pkg::sum_type'(0), tss_pkg::id_type'(k), 1'b1,
                             k == row_count - 1};
                     expected_sums.insert(expected_sums.size(), res);
                  end
               end
               default: begin
                  foreach (fresh_sums[i])
                     expected_sums.insert(expected_sums.size(), fresh_sums[i]);
               end
            endcase
         end
      end
   end

   // Presents one item and holds it until the block takes it. Idle cycles with start low
   // come first, so gaps fall wherever the block happens to be: loading, ordering, folding
   // or streaming results. Between items with no idle cycle, start simply stays high.
   task automatic send_item(input tss_pkg::value_type value, input tss_pkg::parent_type parent,
                            input logic last, input check_kind_type kind,
                            input tss_pkg::sum_type exp_sum, input tss_pkg::id_type exp_count);
      int idle_pct;
      idle_pct = (items_sent < HEAVY_IDLE_FROM) ? 36 : (items_sent < NO_IDLE_FROM) ? 74 : 0;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_node_value   <= value;
      req_parent_index <= parent;
      req_last_node    <= last;
      row_kind         <= kind;
      row_sum          <= exp_sum;
      row_count        <= exp_count;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      items_sent++;
   endtask

   // Node values lean on the extremes now and then; otherwise they are uniform.
   function automatic tss_pkg::value_type pick_value();
      int r;
      r = $urandom_range(9);
      if (r == 0)
         return '0;
      if (r == 1)
         return '1;
      return tss_pkg::value_type'($urandom_range(16'hFFFF));
   endfunction

   // Sends one random tree. Most trees are valid: the nodes are shuffled and each one hangs
   // from the root or from a node placed before it, so parents often carry higher numbers
   // than their children and the level scan needs several passes. Some trees get one parent
   // replaced by noise, which may or may not break them, and a few runs are too long.
   task automatic send_random_tree();
      int r;
      int n;
      int j;
      int swap;
      int order  [MAX_NODES+1];
      int parent [MAX_NODES+1];
      r = $urandom_range(99);
      if (r < 6) begin
         n = $urandom_range(MAX_NODES + 3, MAX_NODES + 1);
         for (int k = 0; k <= n; k++)
            send_item(pick_value(), tss_pkg::parent_type'($urandom_range(MAX_NODES)), k == n,
                      CHECK_PREDICTED, '0, '0);
      end else begin
         n = $urandom_range(MAX_NODES);
         for (int k = 1; k <= n; k++)
            order[k] = k;
         for (int k = n; k > 1; k--) begin
            j = $urandom_range(k, 1);
            swap = order[k];
            order[k] = order[j];
            order[j] = swap;
         end
         for (int k = 1; k <= n; k++)
            if (k == 1 || $urandom_range(k - 1) == 0)
               parent[order[k]] = 0;
            else
               parent[order[k]] = order[$urandom_range(k - 1, 1)];
         if (r < 22 && n > 0)
            parent[$urandom_range(n, 1)] = $urandom_range(MAX_NODES);
         // The root's parent field is ignored by the block, so it carries noise.
         send_item(pick_value(), tss_pkg::parent_type'($urandom_range(MAX_NODES)), n == 0,
                   CHECK_PREDICTED, '0, '0);
         for (int k = 1; k <= n; k++)
            send_item(pick_value(), tss_pkg::parent_type'(parent[k]), k == n,
                      CHECK_PREDICTED, '0, '0);
      end
   endtask

   // Watchdog: a hung block or a lost handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", CYCLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      mismatch_count   = 0;
      items_sent       = 0;
      cycle_count      = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_node_value   = '0;
      req_parent_index = '0;
      req_last_node    = 1'b0;
      row_kind         = CHECK_PREDICTED;
      row_sum          = '0;
      row_count        = '0;
      repeat (8)
         @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].value, directed_rows[i].parent, directed_rows[i].last,
                   directed_rows[i].kind, directed_rows[i].exp_sum,
                   directed_rows[i].exp_count);
      while (items_sent < ITEM_TARGET)
         send_random_tree();
      start <= 1'b0;

      // Wait for every expected result, then give the block time to show anything extra.
      while (expected_sums.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (expected_sums.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_sums.size()));

      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: tree_subtree_sum.f
rtl/tss_pkg.sv
rtl/tree_subtree_sum.sv
bench/tree_subtree_sum_test.sv
